// ===== design/lfps_pkg.sv =====
// ----------------------------------------------------------------------------
// lfps_pkg: shared definitions for the LED flash pattern sequencer
// Mode and phase codes, the per-mode timing record and its reset contents.
// ----------------------------------------------------------------------------
`default_nettype none

package lfps_pkg;

    // Default width of the millisecond time base.
    localparam int TIME_BITS_DEF = 32;

    // Number of blink profiles, one for each display mode.
    localparam int NUM_PROFILES = 6;

    // Width of a packed profile word and of the configuration index.
    localparam int PROFILE_BITS = 48;
    localparam int CFG_INDEX_BITS = 3;

    // Reciprocal of 100 scaled by 2^32; exact for every 24-bit dividend.
    localparam logic [25:0] DIV100_RECIP = 26'd42949673;

    // Display modes.
    typedef enum logic [2:0] {
        MODE_SELF_TEST  = 3'd0,
        MODE_OFF        = 3'd1,
        MODE_ZERO_CROSS = 3'd2,
        MODE_HEATER_ON  = 3'd3,
        MODE_WARNING    = 3'd4,
        MODE_DANGER     = 3'd5
    } mode_t;

    // Request codes as they arrive on the input channel.
    localparam logic [2:0] REQ_SELF_TEST  = 3'd0;
    localparam logic [2:0] REQ_OFF        = 3'd1;
    localparam logic [2:0] REQ_ZERO_CROSS = 3'd2;
    localparam logic [2:0] REQ_HEATER_ON  = 3'd3;
    localparam logic [2:0] REQ_WARNING    = 3'd4;
    localparam logic [2:0] REQ_DANGER     = 3'd5;
    localparam logic [2:0] REQ_CANCEL     = 3'd6;

    // Command codes.
    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    // Blink phases.
    typedef enum logic [1:0] {
        PH_STOP  = 2'd0,
        PH_ON    = 2'd1,
        PH_OFF   = 2'd2,
        PH_QUIET = 2'd3
    } phase_t;

    // Timing derived from one profile, ready for the sequencer to use.
    typedef struct packed {
        logic [7:0]  count;
        logic [15:0] on_ms;
        logic [15:0] off_ms;
        logic [15:0] quiet_ms;
    } blink_timing_t;

    // Reset contents of the profile registers, in register order.
    localparam logic [PROFILE_BITS-1:0] PROFILE_RESET [NUM_PROFILES] = '{
        48'd4295071236221,
        48'd0,
        48'd4294987351016,
        48'd4295004127732,
        48'd8589988200573,
        48'd1610666344573
    };

    // Period times duty percent.
    function automatic logic [23:0] duty_product(input logic [PROFILE_BITS-1:0] prof);
        logic [23:0] prod;
        prod = prof[15:0] * prof[23:16];
        return prod;
    endfunction

    // Builds the timing record from a profile and its already divided on time.
    function automatic blink_timing_t timing_of(input logic [PROFILE_BITS-1:0] prof,
                                                input logic [15:0] on_ms);
        blink_timing_t t;
        logic [23:0]   burst;
        burst      = prof[31:24] * prof[15:0];
        t.count    = prof[31:24];
        t.on_ms    = on_ms;
        t.off_ms   = prof[15:0] - on_ms;
        t.quiet_ms = prof[47:32] - burst[15:0];
        return t;
    endfunction

    // Timing table contents after reset.
    localparam blink_timing_t TIMING_RESET [NUM_PROFILES] = '{
        timing_of(PROFILE_RESET[0], 16'(duty_product(PROFILE_RESET[0]) / 100)),
        timing_of(PROFILE_RESET[1], 16'(duty_product(PROFILE_RESET[1]) / 100)),
        timing_of(PROFILE_RESET[2], 16'(duty_product(PROFILE_RESET[2]) / 100)),
        timing_of(PROFILE_RESET[3], 16'(duty_product(PROFILE_RESET[3]) / 100)),
        timing_of(PROFILE_RESET[4], 16'(duty_product(PROFILE_RESET[4]) / 100)),
        timing_of(PROFILE_RESET[5], 16'(duty_product(PROFILE_RESET[5]) / 100))
    };

endpackage

`default_nettype wire

// ===== design/lfps_if.sv =====
// ----------------------------------------------------------------------------
// lfps_if: channel interfaces of the LED flash pattern sequencer
// Input word channel, result word channel and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

// One tick or mode request per word.
interface lfps_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [2:0] requested_mode;

    modport source (output valid, output cmd, output requested_mode, input ready);
    modport sink   (input valid, input cmd, input requested_mode, output ready);
endinterface

// One result word per accepted input word.
interface lfps_out_if;
    logic       valid;
    logic       ready;
    logic       led_on;
    logic [2:0] mode_now;
    logic [1:0] phase_now;

    modport source (output valid, output led_on, output mode_now, output phase_now,
                    input ready);
    modport sink   (input valid, input led_on, input mode_now, input phase_now,
                    output ready);
endinterface

// Profile register writes.
interface lfps_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [47:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/lfps_profile_timing.sv =====
// ----------------------------------------------------------------------------
// lfps_profile_timing: per-mode blink timing table
// Turns each profile write into on, off and quiet times through a short
// two-stage pipeline and holds the results for the sequencer to load.
// ----------------------------------------------------------------------------
`default_nettype none

module lfps_profile_timing (
    input  logic                  clk,
    input  logic                  rst_n,
    lfps_cfg_if.sink              cfg,
    input  lfps_pkg::mode_t       rd_mode,
    output lfps_pkg::blink_timing_t rd_timing,
    output logic                  busy
);
    import lfps_pkg::*;

    logic                    cfg_fire;
    logic                    s1_valid_reg;
    logic [CFG_INDEX_BITS-1:0] s1_idx_reg;
    logic [PROFILE_BITS-1:0] s1_prof_reg;
    logic [23:0]             s1_prod_reg;
    logic                    s2_valid_reg;
    logic [CFG_INDEX_BITS-1:0] s2_idx_reg;
    logic [PROFILE_BITS-1:0] s2_prof_reg;
    logic [15:0]             s2_on_reg;
    logic [49:0]             quot_full;
    blink_timing_t           timing_reg [NUM_PROFILES];

    // Writes beyond the register list are taken and ignored.
    assign cfg.ready = ~busy;
    assign cfg_fire  = cfg.valid & cfg.ready &
                       (cfg.index < CFG_INDEX_BITS'(NUM_PROFILES));
    assign busy      = s1_valid_reg | s2_valid_reg;

    // Division by 100 as a multiplication by the scaled reciprocal.
    assign quot_full = s1_prod_reg * DIV100_RECIP;

    // Pipeline valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cfg_fire;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Pipeline payload: product first, then the quotient.
    always_ff @(posedge clk)
    begin
        if (cfg_fire)
        begin
            s1_idx_reg  <= cfg.index;
            s1_prof_reg <= cfg.data;
            s1_prod_reg <= duty_product(cfg.data);
        end
        if (s1_valid_reg)
        begin
            s2_idx_reg  <= s1_idx_reg;
            s2_prof_reg <= s1_prof_reg;
            s2_on_reg   <= quot_full[47:32];
        end
    end

    // Timing table, loaded with the default profiles at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PROFILES; i++)
            begin
                timing_reg[i] <= TIMING_RESET[i];
            end
        end
        else if (s2_valid_reg)
        begin
            timing_reg[s2_idx_reg] <= timing_of(s2_prof_reg, s2_on_reg);
        end
    end

    assign rd_timing = timing_reg[rd_mode];

endmodule

`default_nettype wire

// ===== design/led_flash_pattern_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// led_flash_pattern_sequencer_top: status LED blink sequencer
// Mode requests follow a priority ladder and load a blink timing; millisecond
// ticks step a four-phase stopped/on/off/quiet machine that drives the LED.
// ----------------------------------------------------------------------------
// An accepted word passes through the input register, then the result register, to its
// result word; one word is accepted in every cycle unless the result channel stalls or a
// profile write holds both ready lines low while the timing pipeline runs. Reset puts the
// mode at off, the phase at stopped, the LED dark, the time base at zero and the default
// profiles into the table.
`default_nettype none

module led_flash_pattern_sequencer_top #(
    parameter int TIME_BITS = lfps_pkg::TIME_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    lfps_in_if.sink   items,
    lfps_out_if.source results,
    lfps_cfg_if.sink  cfg
);
    import lfps_pkg::*;

    // Input register.
    logic       in_valid_reg;
    logic       cmd_reg;
    logic [2:0] req_reg;

    // Result register.
    logic       out_valid_reg;
    logic       out_led_reg;
    mode_t      out_mode_reg;
    phase_t     out_phase_reg;

    // Sequencer state.
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic [TIME_BITS-1:0] deadline_reg, deadline_next;
    logic [TIME_BITS-1:0] cycle_start_reg, cycle_start_next;
    logic [7:0]           flashes_reg, flashes_next;
    mode_t                mode_reg, mode_next;
    phase_t               phase_reg, phase_next;
    logic                 led_reg, led_next;
    blink_timing_t        active_reg, active_next;

    logic                 proc_fire;
    logic                 busy;
    mode_t                rd_mode;
    mode_t                mode_sel;
    blink_timing_t        rd_timing;
    logic [TIME_BITS-1:0] time_inc;
    logic                 step_due;
    logic [TIME_BITS-1:0] add_base;
    logic [15:0]          add_ofs;
    logic [TIME_BITS-1:0] add_sum;

    // Timing table and its write pipeline.
    lfps_profile_timing u_timing (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .rd_mode   (rd_mode),
        .rd_timing (rd_timing),
        .busy      (busy)
    );

    // Handshakes: a word moves on when the result register is free or draining.
    assign proc_fire   = in_valid_reg & (~out_valid_reg | results.ready);
    assign items.ready = ~busy & (~in_valid_reg | proc_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (items.valid && items.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proc_fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
        begin
            cmd_reg <= items.cmd;
            req_reg <= items.requested_mode;
        end
    end

    // Deadline adder: base is the cycle start only when entering quiet.
    assign time_inc = time_reg + TIME_BITS'(1);
    assign step_due = (mode_reg != MODE_OFF) && (time_inc > deadline_reg);
    assign add_base = (phase_reg == PH_OFF && flashes_reg == 8'd0) ? cycle_start_reg
                                                                   : time_inc;
    assign add_ofs  = (phase_reg == PH_ON) ? active_reg.off_ms :
                      (phase_reg == PH_OFF && flashes_reg == 8'd0) ? active_reg.quiet_ms :
                      active_reg.on_ms;
    assign add_sum  = add_base + TIME_BITS'(add_ofs);

    // Priority ladder for mode requests.
    always_comb
    begin
        mode_sel = mode_reg;
        unique case (req_reg) inside
            REQ_SELF_TEST:
            begin
                if (mode_reg == MODE_SELF_TEST || mode_reg == MODE_OFF)
                begin
                    mode_sel = MODE_SELF_TEST;
                end
            end
            REQ_OFF, REQ_CANCEL: mode_sel = MODE_OFF;
            REQ_ZERO_CROSS:
            begin
                if (mode_reg < MODE_HEATER_ON)
                begin
                    mode_sel = MODE_ZERO_CROSS;
                end
            end
            REQ_HEATER_ON:
            begin
                if (mode_reg < MODE_WARNING)
                begin
                    mode_sel = MODE_HEATER_ON;
                end
            end
            REQ_WARNING:
            begin
                if (mode_reg < MODE_DANGER)
                begin
                    mode_sel = MODE_WARNING;
                end
            end
            REQ_DANGER: mode_sel = MODE_DANGER;
            default:    mode_sel = mode_reg;
        endcase
    end

    // Next state for one word.
    always_comb
    begin
        time_next        = time_reg;
        deadline_next    = deadline_reg;
        cycle_start_next = cycle_start_reg;
        flashes_next     = flashes_reg;
        mode_next        = mode_reg;
        phase_next       = phase_reg;
        led_next         = led_reg;
        active_next      = active_reg;
        rd_mode          = mode_sel;

        if (proc_fire)
        begin
            if (cmd_reg == CMD_REQUEST)
            begin
                // A request changes the mode and loads its timing only.
                mode_next   = mode_sel;
                active_next = rd_timing;
            end
            else
            begin
                time_next = time_inc;
                if (step_due)
                begin
                    unique case (phase_reg)
                        PH_STOP:
                        begin
                            flashes_next     = active_reg.count - 8'd1;
                            cycle_start_next = time_inc;
                            deadline_next    = add_sum;
                            led_next         = 1'b1;
                            phase_next       = PH_ON;
                        end
                        PH_ON:
                        begin
                            deadline_next = add_sum;
                            led_next      = 1'b0;
                            phase_next    = PH_OFF;
                        end
                        PH_OFF:
                        begin
                            deadline_next = add_sum;
                            if (flashes_reg != 8'd0)
                            begin
                                led_next     = 1'b1;
                                flashes_next = flashes_reg - 8'd1;
                                phase_next   = PH_ON;
                            end
                            else
                            begin
                                phase_next = PH_QUIET;
                            end
                        end
                        PH_QUIET:
                        begin
                            if (mode_reg == MODE_WARNING || mode_reg == MODE_DANGER)
                            begin
                                // Repeating modes start the next cycle.
                                flashes_next     = active_reg.count - 8'd1;
                                cycle_start_next = time_inc;
                                deadline_next    = add_sum;
                                led_next         = 1'b1;
                                phase_next       = PH_ON;
                            end
                            else
                            begin
                                // Single-shot modes fall back to off.
                                rd_mode     = MODE_OFF;
                                mode_next   = MODE_OFF;
                                active_next = rd_timing;
                                phase_next  = PH_STOP;
                            end
                        end
                        default: phase_next = phase_reg;
                    endcase
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg        <= '0;
            deadline_reg    <= '0;
            cycle_start_reg <= '0;
            flashes_reg     <= '0;
            mode_reg        <= MODE_OFF;
            phase_reg       <= PH_STOP;
            led_reg         <= 1'b0;
            active_reg      <= '0;
        end
        else
        begin
            time_reg        <= time_next;
            deadline_reg    <= deadline_next;
            cycle_start_reg <= cycle_start_next;
            flashes_reg     <= flashes_next;
            mode_reg        <= mode_next;
            phase_reg       <= phase_next;
            led_reg         <= led_next;
            active_reg      <= active_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire)
        begin
            out_led_reg   <= led_next;
            out_mode_reg  <= mode_next;
            out_phase_reg <= phase_next;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.led_on    = out_led_reg;
    assign results.mode_now  = out_mode_reg;
    assign results.phase_now = out_phase_reg;

    // The LED is lit exactly while the machine sits in the on phase.
    a_led_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
        led_reg == (phase_reg == PH_ON))
        else $error("LED level disagrees with phase");

    // No word enters while the timing table is being rewritten.
    a_busy_blocks_items: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !items.ready)
        else $error("input accepted during timing update");

    // A tick advances the time base by exactly one.
    a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && cmd_reg == CMD_TICK) |=> time_reg == $past(time_reg) + TIME_BITS'(1))
        else $error("tick did not advance time");

    // An off or cancel request always lands in off.
    a_off_wins: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && cmd_reg == CMD_REQUEST && (req_reg == REQ_OFF || req_reg == REQ_CANCEL))
        |=> mode_reg == MODE_OFF)
        else $error("off request not taken");

endmodule

`default_nettype wire
